// ----- rtl/sdl_pkg.sv -----
// Shared types and defaults for the sorted deque list.
`default_nettype none

package sdl_pkg;

   localparam int DEFAULT_DEPTH     = 64;
   localparam int DEFAULT_KEY_WIDTH = 16;

   typedef enum logic [3:0] {
      K_ADD_FRONT = 4'd0,
      K_ADD_REAR  = 4'd1,
      K_POP_FRONT = 4'd2,
      K_POP_REAR  = 4'd3,
      K_DEL_FIRST = 4'd4,
      K_DEL_ALL   = 4'd5,
      K_INS_ASC   = 4'd6,
      K_INS_DESC  = 4'd7,
      K_SEARCH    = 4'd8,
      K_READ_FWD  = 4'd9,
      K_READ_REV  = 4'd10
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_EMPTY   = 2'd1,
      STAT_FULL    = 2'd2,
      STAT_MISSING = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_POP,
      S_SCAN,
      S_SEARCH,
      S_READOUT,
      S_INS_REAR,
      S_INS_FRONT,
      S_WALK,
      S_SHIFT,
      S_INS_PUT
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/sdl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sdl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ----- rtl/sorted_deque_list.sv -----
// Top level of the sorted deque list: sequencer, compare unit and key store.
//
//   channel   ports                          handshake
//   request   req_kind, req_key_value        start high while busy low
//   response  rsp_out_value .. rsp_last      rsp_strobe, one cycle, no backpressure
//
// Add front/rear never raises busy; pop reads, then returns the key. Search,
// delete and readout stream the stored keys through the single RAM read port,
// one per cycle. Sorted insert appends at the rear, else checks the head key,
// walks if needed, shifts the tail up and writes. Reset clears state, count,
// head, pv, strobe only; the key store needs no clearing pass. Results cannot
// be stalled; busy stays high until the last result of a request is shown.
`default_nettype none

module sorted_deque_list #(
   parameter int DEPTH     = sdl_pkg::DEFAULT_DEPTH,
   parameter int KEY_WIDTH = sdl_pkg::DEFAULT_KEY_WIDTH
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [3:0]                   req_kind,
   input  wire logic [KEY_WIDTH-1:0]         req_key_value,
   output logic                              rsp_strobe,
   output logic      [KEY_WIDTH-1:0]         rsp_out_value,
   output logic      [1:0]                   rsp_status,
   output logic                              rsp_found,
   output logic      [$clog2(DEPTH+1)-1:0]   rsp_compares,
   output logic      [$clog2(DEPTH+1)-1:0]   rsp_entries,
   output logic                              rsp_last
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] h,
                                                input logic [CNT_W-1:0] l);
      logic [CNT_W:0] s;
      s = (CNT_W+1)'(h) + (CNT_W+1)'(l);
      if (s >= (CNT_W+1)'(DEPTH)) begin
         s = s - (CNT_W+1)'(DEPTH);
      end
      return s[IDX_W-1:0];
   endfunction

   sdl_pkg::state_type  state_ff, state_in;
   sdl_pkg::kind_type   kind_ff, kind_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    head_ff, head_in;
   logic [CNT_W-1:0]    iss_ff, iss_in;
   logic [CNT_W-1:0]    len_ff, len_in;
   logic [CNT_W-1:0]    base_ff, base_in;
   logic                up_ff, up_in;
   logic                pv_ff, pv_in;
   logic [CNT_W-1:0]    pidx_ff, pidx_in;
   logic [CNT_W-1:0]    pord_ff, pord_in;
   logic [CNT_W-1:0]    wn_ff, wn_in;
   logic                hit_ff, hit_in;
   logic [CNT_W-1:0]    pos_ff, pos_in;

   logic                 strobe_ff, strobe_in;
   logic [KEY_WIDTH-1:0] value_ff, value_in;
   sdl_pkg::status_type  status_ff, status_in;
   logic                 found_ff, found_in;
   logic [CNT_W-1:0]     compares_ff, compares_in;
   logic [CNT_W-1:0]     entries_ff;
   logic                 last_ff, last_in;

   logic                 ram_we;
   logic [IDX_W-1:0]     ram_waddr;
   logic [KEY_WIDTH-1:0] ram_wdata;
   logic [IDX_W-1:0]     ram_raddr;
   logic [KEY_WIDTH-1:0] ram_rdata;

   sdl_pkg::kind_type req_code;
   logic              acc;
   logic              is_full;
   logic              is_empty;
   logic              streaming;
   logic              iss_go;
   logic [CNT_W-1:0]  lidx_iss;
   logic              eq;
   logic              le;
   logic              ge;
   logic              asc;
   logic              walk_ok;
   logic              front_ok;
   logic              plast;
   logic              keep;

   sdl_ram #(
      .WIDTH (KEY_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_code  = sdl_pkg::kind_type'(req_kind);
   assign acc       = start && (state_ff == sdl_pkg::S_IDLE);
   assign busy      = (state_ff != sdl_pkg::S_IDLE);
   assign is_full   = (count_ff == CNT_W'(DEPTH));
   assign is_empty  = (count_ff == '0);
   assign streaming = (state_ff == sdl_pkg::S_SCAN) || (state_ff == sdl_pkg::S_SEARCH) ||
                      (state_ff == sdl_pkg::S_READOUT) || (state_ff == sdl_pkg::S_WALK) ||
                      (state_ff == sdl_pkg::S_SHIFT);
   assign iss_go    = streaming && (iss_ff < len_ff);
   assign lidx_iss  = up_ff ? (base_ff + iss_ff) : (base_ff - iss_ff);

   // shared compare unit
   assign eq       = (ram_rdata == key_ff);
   assign le       = (ram_rdata <= key_ff);
   assign ge       = (ram_rdata >= key_ff);
   assign asc      = (kind_ff == sdl_pkg::K_INS_ASC);
   assign walk_ok  = asc ? le : ge;
   assign front_ok = asc ? ge : le;
   assign plast    = (pord_ff == (len_ff - CNT_W'(1)));
   assign keep     = !(eq && ((kind_ff == sdl_pkg::K_DEL_ALL) || !hit_ff));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sdl_pkg::S_IDLE: begin
            if (acc) begin
               unique case (req_code)
                  sdl_pkg::K_POP_FRONT, sdl_pkg::K_POP_REAR: begin
                     if (!is_empty) state_in = sdl_pkg::S_POP;
                  end
                  sdl_pkg::K_DEL_FIRST, sdl_pkg::K_DEL_ALL: begin
                     if (!is_empty) state_in = sdl_pkg::S_SCAN;
                  end
                  sdl_pkg::K_INS_ASC, sdl_pkg::K_INS_DESC: begin
                     if (!is_full && !is_empty) state_in = sdl_pkg::S_INS_REAR;
                  end
                  sdl_pkg::K_SEARCH: begin
                     if (!is_empty) state_in = sdl_pkg::S_SEARCH;
                  end
                  sdl_pkg::K_READ_FWD, sdl_pkg::K_READ_REV: begin
                     if (!is_empty) state_in = sdl_pkg::S_READOUT;
                  end
                  default: begin
                     state_in = sdl_pkg::S_IDLE;
                  end
               endcase
            end
         end
         sdl_pkg::S_POP: begin
            state_in = sdl_pkg::S_IDLE;
         end
         sdl_pkg::S_SCAN: begin
            if (pv_ff && plast) state_in = sdl_pkg::S_IDLE;
         end
         sdl_pkg::S_SEARCH: begin
            if (pv_ff && (eq || plast)) state_in = sdl_pkg::S_IDLE;
         end
         sdl_pkg::S_READOUT: begin
            if (pv_ff && plast) state_in = sdl_pkg::S_IDLE;
         end
         sdl_pkg::S_INS_REAR: begin
            state_in = walk_ok ? sdl_pkg::S_IDLE : sdl_pkg::S_INS_FRONT;
         end
         sdl_pkg::S_INS_FRONT: begin
            state_in = front_ok ? sdl_pkg::S_SHIFT : sdl_pkg::S_WALK;
         end
         sdl_pkg::S_WALK: begin
            if (pv_ff && !walk_ok) state_in = sdl_pkg::S_SHIFT;
         end
         sdl_pkg::S_SHIFT: begin
            if (pv_ff && plast) state_in = sdl_pkg::S_INS_PUT;
         end
         sdl_pkg::S_INS_PUT: begin
            state_in = sdl_pkg::S_IDLE;
         end
         default: begin
            state_in = sdl_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      kind_in     = kind_ff;
      key_in      = key_ff;
      count_in    = count_ff;
      head_in     = head_ff;
      iss_in      = iss_ff;
      len_in      = len_ff;
      base_in     = base_ff;
      up_in       = up_ff;
      pv_in       = 1'b0;
      pidx_in     = pidx_ff;
      pord_in     = pord_ff;
      wn_in       = wn_ff;
      hit_in      = hit_ff;
      pos_in      = pos_ff;
      ram_we      = 1'b0;
      ram_waddr   = slot_of(head_ff, count_ff);
      ram_wdata   = key_ff;
      ram_raddr   = slot_of(head_ff, lidx_iss);
      strobe_in   = 1'b0;
      value_in    = '0;
      status_in   = sdl_pkg::STAT_OK;
      found_in    = 1'b0;
      compares_in = '0;
      last_in     = 1'b1;

      // advance the read stream
      if (iss_go) begin
         iss_in  = iss_ff + CNT_W'(1);
         pv_in   = 1'b1;
         pidx_in = lidx_iss;
         pord_in = iss_ff;
      end

      unique case (state_ff)
         sdl_pkg::S_IDLE: begin
            if (acc) begin
               kind_in = req_code;
               key_in  = req_key_value;
               iss_in  = '0;
               wn_in   = '0;
               hit_in  = 1'b0;
               base_in = '0;
               up_in   = 1'b1;
               len_in  = count_ff;
               unique case (req_code)
                  sdl_pkg::K_ADD_FRONT, sdl_pkg::K_ADD_REAR: begin
                     strobe_in = 1'b1;
                     if (is_full) begin
                        status_in = sdl_pkg::STAT_FULL;
                     end else begin
                        ram_we    = 1'b1;
                        ram_wdata = req_key_value;
                        count_in  = count_ff + CNT_W'(1);
                        if (req_code == sdl_pkg::K_ADD_FRONT) begin
                           head_in   = (head_ff == '0) ? IDX_W'(DEPTH - 1)
                                                       : head_ff - IDX_W'(1);
                           ram_waddr = head_in;
                        end
                     end
                  end
                  sdl_pkg::K_POP_FRONT, sdl_pkg::K_POP_REAR: begin
                     if (is_empty) begin
                        strobe_in = 1'b1;
                        status_in = sdl_pkg::STAT_EMPTY;
                     end else begin
                        ram_raddr = slot_of(head_ff, (req_code == sdl_pkg::K_POP_FRONT)
                                                     ? '0 : count_ff - CNT_W'(1));
                     end
                  end
                  sdl_pkg::K_INS_ASC, sdl_pkg::K_INS_DESC: begin
                     if (is_full) begin
                        strobe_in = 1'b1;
                        status_in = sdl_pkg::STAT_FULL;
                     end else if (is_empty) begin
                        strobe_in = 1'b1;
                        ram_we    = 1'b1;
                        ram_waddr = head_ff;
                        ram_wdata = req_key_value;
                        count_in  = CNT_W'(1);
                     end else begin
                        ram_raddr = slot_of(head_ff, count_ff - CNT_W'(1));
                     end
                  end
                  sdl_pkg::K_DEL_FIRST, sdl_pkg::K_DEL_ALL, sdl_pkg::K_SEARCH,
                  sdl_pkg::K_READ_FWD: begin
                     if (is_empty) begin
                        strobe_in = 1'b1;
                        status_in = sdl_pkg::STAT_EMPTY;
                     end
                  end
                  sdl_pkg::K_READ_REV: begin
                     base_in = count_ff - CNT_W'(1);
                     up_in   = 1'b0;
                     if (is_empty) begin
                        strobe_in = 1'b1;
                        status_in = sdl_pkg::STAT_EMPTY;
                     end
                  end
                  default: begin
                     strobe_in = 1'b1;
                  end
               endcase
            end
         end
         sdl_pkg::S_POP: begin
            strobe_in = 1'b1;
            value_in  = ram_rdata;
            count_in  = count_ff - CNT_W'(1);
            if (kind_ff == sdl_pkg::K_POP_FRONT) begin
               head_in = slot_of(head_ff, CNT_W'(1));
            end
         end
         sdl_pkg::S_SCAN: begin
            if (pv_ff) begin
               if (keep) begin
                  ram_we    = 1'b1;
                  ram_waddr = slot_of(head_ff, wn_ff);
                  ram_wdata = ram_rdata;
                  wn_in     = wn_ff + CNT_W'(1);
               end else begin
                  hit_in = 1'b1;
               end
               if (plast) begin
                  strobe_in = 1'b1;
                  if (hit_ff || !keep) begin
                     count_in = wn_ff + CNT_W'(keep);
                     value_in = key_ff;
                     found_in = 1'b1;
                  end else begin
                     status_in = sdl_pkg::STAT_MISSING;
                  end
               end
            end
         end
         sdl_pkg::S_SEARCH: begin
            if (pv_ff) begin
               if (eq) begin
                  strobe_in   = 1'b1;
                  found_in    = 1'b1;
                  compares_in = pord_ff + CNT_W'(1);
               end else if (plast) begin
                  strobe_in   = 1'b1;
                  status_in   = sdl_pkg::STAT_MISSING;
                  compares_in = len_ff;
               end
            end
         end
         sdl_pkg::S_READOUT: begin
            if (pv_ff) begin
               strobe_in = 1'b1;
               value_in  = ram_rdata;
               last_in   = plast;
            end
         end
         sdl_pkg::S_INS_REAR: begin
            if (walk_ok) begin
               strobe_in = 1'b1;
               ram_we    = 1'b1;
               count_in  = count_ff + CNT_W'(1);
            end else begin
               ram_raddr = head_ff;
            end
         end
         sdl_pkg::S_INS_FRONT: begin
            iss_in = '0;
            if (front_ok) begin
               pos_in  = '0;
               base_in = count_ff - CNT_W'(1);
               len_in  = count_ff;
               up_in   = 1'b0;
            end else begin
               base_in = CNT_W'(1);
               len_in  = count_ff - CNT_W'(1);
               up_in   = 1'b1;
            end
         end
         sdl_pkg::S_WALK: begin
            if (pv_ff && !walk_ok) begin
               pos_in  = pidx_ff;
               base_in = count_ff - CNT_W'(1);
               len_in  = count_ff - pidx_ff;
               up_in   = 1'b0;
               iss_in  = '0;
               pv_in   = 1'b0;
            end
         end
         sdl_pkg::S_SHIFT: begin
            if (pv_ff) begin
               ram_we    = 1'b1;
               ram_waddr = slot_of(head_ff, pidx_ff + CNT_W'(1));
               ram_wdata = ram_rdata;
            end
         end
         sdl_pkg::S_INS_PUT: begin
            strobe_in = 1'b1;
            ram_we    = 1'b1;
            ram_waddr = slot_of(head_ff, pos_ff);
            count_in  = count_ff + CNT_W'(1);
         end
         default: begin
            pv_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= sdl_pkg::S_IDLE;
         count_ff  <= '0;
         head_ff   <= '0;
         pv_ff     <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         head_ff   <= head_in;
         pv_ff     <= pv_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      key_ff      <= key_in;
      iss_ff      <= iss_in;
      len_ff      <= len_in;
      base_ff     <= base_in;
      up_ff       <= up_in;
      pidx_ff     <= pidx_in;
      pord_ff     <= pord_in;
      wn_ff       <= wn_in;
      hit_ff      <= hit_in;
      pos_ff      <= pos_in;
      value_ff    <= value_in;
      status_ff   <= status_in;
      found_ff    <= found_in;
      compares_ff <= compares_in;
      entries_ff  <= count_in;
      last_ff     <= last_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_out_value = value_ff;
   assign rsp_status    = status_ff;
   assign rsp_found     = found_ff;
   assign rsp_compares  = compares_ff;
   assign rsp_entries   = entries_ff;
   assign rsp_last      = last_ff;

endmodule

`default_nettype wire
